[src/vteg_pkg.sv]
// Shared types, codes and the per-term multiply schedule for the valence term unit.
package vteg_pkg;

    // Item kinds (s_tuser[1:0])
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_EVAL  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Term types (s_tuser[3:2])
    localparam logic [1:0] TERM_HARM  = 2'd0;
    localparam logic [1:0] TERM_QUART = 2'd1;
    localparam logic [1:0] TERM_CROSS = 2'd2;
    localparam logic [1:0] TERM_BAD   = 2'd3;

    // Multiplier operand sources
    typedef logic [3:0] opd_t;
    localparam opd_t OPD_Q0 = 4'd0;
    localparam opd_t OPD_R2 = 4'd1;
    localparam opd_t OPD_R3 = 4'd2;
    localparam opd_t OPD_R4 = 4'd3;
    localparam opd_t OPD_X0 = 4'd4;
    localparam opd_t OPD_X1 = 4'd5;
    localparam opd_t OPD_A  = 4'd6;
    localparam opd_t OPD_B  = 4'd7;
    localparam opd_t OPD_C  = 4'd8;
    localparam opd_t OPD_D  = 4'd9;

    // Where a scaled product goes
    typedef logic [3:0] dst_t;
    localparam dst_t DST_R2   = 4'd0;  // sat32 into r2
    localparam dst_t DST_R3   = 4'd1;
    localparam dst_t DST_R4   = 4'd2;
    localparam dst_t DST_E    = 4'd3;  // energy partial sum
    localparam dst_t DST_EH   = 4'd4;  // energy partial sum, extra halving
    localparam dst_t DST_G0X1 = 4'd5;  // first gradient, times 1..4
    localparam dst_t DST_G0X2 = 4'd6;
    localparam dst_t DST_G0X3 = 4'd7;
    localparam dst_t DST_G0X4 = 4'd8;
    localparam dst_t DST_G1   = 4'd9;  // second gradient of a cross term

    // Gradient table address select
    typedef logic [1:0] gadr_t;
    localparam gadr_t GADR_I0  = 2'd0;
    localparam gadr_t GADR_I1  = 2'd1;
    localparam gadr_t GADR_CLR = 2'd2;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_idx_t;

    typedef struct packed {
        opd_t opa;
        opd_t opb;
        dst_t dst;
        logic last;
    } step_t;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        logic  coord_we;
        logic  coord_re;
        logic  coord_sel_i1;
        logic  grad_we;
        logic  grad_re;
        logic  grad_zero;
        gadr_t grad_sel;
        logic  ld_q0;
        logic  ld_q1;
        logic  sub;
        logic  init;
        logic  mul_en;
        opd_t  opa;
        opd_t  opb;
        logic  acc_en;
        dst_t  dst;
        logic  e_commit;
        logic  clr_energy;
        logic  cap_gread;
        logic  clr_step;
        logic  out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] ttype;
        logic       clr_last;
    } sts_t;

    // Multiply schedule of each term type
    function automatic step_t step_op(input logic [1:0] ttype, input step_idx_t step);
        step_t s;
        s = '{opa: OPD_A, opb: OPD_A, dst: DST_E, last: 1'b1};
        unique case (ttype)
            TERM_HARM:
            begin
                unique case (step)
                    4'd0:    s = '{opa: OPD_X0, opb: OPD_X0, dst: DST_R2,   last: 1'b0};
                    4'd1:    s = '{opa: OPD_A,  opb: OPD_R2, dst: DST_EH,   last: 1'b0};
                    default: s = '{opa: OPD_A,  opb: OPD_X0, dst: DST_G0X1, last: 1'b1};
                endcase
            end
            TERM_QUART:
            begin
                unique case (step)
                    4'd0:    s = '{opa: OPD_Q0, opb: OPD_Q0, dst: DST_R2,   last: 1'b0};
                    4'd1:    s = '{opa: OPD_R2, opb: OPD_Q0, dst: DST_R3,   last: 1'b0};
                    4'd2:    s = '{opa: OPD_R3, opb: OPD_Q0, dst: DST_R4,   last: 1'b0};
                    4'd3:    s = '{opa: OPD_A,  opb: OPD_Q0, dst: DST_E,    last: 1'b0};
                    4'd4:    s = '{opa: OPD_B,  opb: OPD_R2, dst: DST_E,    last: 1'b0};
                    4'd5:    s = '{opa: OPD_C,  opb: OPD_R3, dst: DST_E,    last: 1'b0};
                    4'd6:    s = '{opa: OPD_D,  opb: OPD_R4, dst: DST_E,    last: 1'b0};
                    4'd7:    s = '{opa: OPD_B,  opb: OPD_Q0, dst: DST_G0X2, last: 1'b0};
                    4'd8:    s = '{opa: OPD_C,  opb: OPD_R2, dst: DST_G0X3, last: 1'b0};
                    default: s = '{opa: OPD_D,  opb: OPD_R3, dst: DST_G0X4, last: 1'b1};
                endcase
            end
            TERM_CROSS:
            begin
                unique case (step)
                    4'd0:    s = '{opa: OPD_X0, opb: OPD_X1, dst: DST_R2,   last: 1'b0};
                    4'd1:    s = '{opa: OPD_A,  opb: OPD_R2, dst: DST_E,    last: 1'b0};
                    4'd2:    s = '{opa: OPD_A,  opb: OPD_X1, dst: DST_G0X1, last: 1'b0};
                    default: s = '{opa: OPD_A,  opb: OPD_X0, dst: DST_G1,   last: 1'b1};
                endcase
            end
            default: s = '{opa: OPD_A, opb: OPD_A, dst: DST_E, last: 1'b1};
        endcase
        return s;
    endfunction

endpackage

[src/valence_term_energy_gradient.sv]
// Top level of the valence term energy and gradient unit.
// One item is handled at a time on a single shared 32x32 multiplier, with one write and one
// read port per table. Each multiply takes a multiply state and an accumulate state, and each
// coordinate used adds a gradient read-modify-write. A new beat is taken while the previous
// result still waits on the output. After reset the gradient table is swept to zero, one
// entry a cycle, across all NUM_COORDS entries before s_tready first rises. Arithmetic is
// Q8.24 in, Q40.24 accumulated, with saturation and a sticky overflow flag cleared by
// clear-energy.
module valence_term_energy_gradient #(
    parameter int NUM_COORDS = 256,
    parameter int FRAC_BITS  = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [175:0] s_tdata,   // first_index, second_index, coord_value,
                                    // coef_a, coef_b, coef_c, coef_d
    input  logic [3:0]   s_tuser,   // kind, term_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // energy_sum, grad_read
    output logic [1:0]   m_tuser    // overflow_flag, bad_type
);

    vteg_pkg::cmd_t cmd;
    vteg_pkg::sts_t sts;

    vteg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vteg_dp #(.NUM_COORDS(NUM_COORDS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

    // One item in flight: no second beat right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while busy");

    // Gradient table is never written while the block waits for a beat
    a_grad_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grad_we |-> !s_tready)
        else $error("gradient write while idle");

    // A result appears only after the result register was loaded
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result valid without load");

endmodule

[src/vteg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vteg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/vteg_dp.sv]
// Datapath: coordinate and gradient tables, shared multiplier, accumulators, result register.
module vteg_dp #(
    parameter int NUM_COORDS = 256,
    parameter int FRAC_BITS  = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vteg_pkg::cmd_t    cmd,
    output vteg_pkg::sts_t    sts,
    input  logic [175:0]      in_data,
    input  logic [3:0]        in_user,
    output logic [127:0]      out_data,
    output logic [1:0]        out_user
);

    localparam int IDX_W = $clog2(NUM_COORDS);
    localparam logic signed [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN64 = 64'h8000_0000_0000_0000;

    // Index taken modulo the table depth by restoring reduction
    function automatic logic [IDX_W-1:0] idx_mod(input logic [7:0] raw);
        logic [31:0] rem;
        rem = {24'd0, raw};
        for (int k = 8; k >= 0; k--)
        begin
            if (rem >= (32'(NUM_COORDS) << k))
            begin
                rem = rem - (32'(NUM_COORDS) << k);
            end
        end
        return rem[IDX_W-1:0];
    endfunction

    // Clamp to signed 32 bits, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v[63:31] != {33{v[63]}})
        begin
            return {1'b1, v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Saturating 64-bit add, flag in the top bit
    function automatic logic [64:0] sat_add(input logic signed [63:0] x,
                                            input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63])
        begin
            return {1'b1, s[64] ? MIN64 : MAX64};
        end
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic signed [31:0] opd_pick(
        input vteg_pkg::opd_t code,
        input logic signed [31:0] q0, r2, r3, r4, x0, x1, a, b, c, d);
        logic signed [31:0] v;
        unique case (code)
            vteg_pkg::OPD_Q0: v = q0;
            vteg_pkg::OPD_R2: v = r2;
            vteg_pkg::OPD_R3: v = r3;
            vteg_pkg::OPD_R4: v = r4;
            vteg_pkg::OPD_X0: v = x0;
            vteg_pkg::OPD_X1: v = x1;
            vteg_pkg::OPD_A:  v = a;
            vteg_pkg::OPD_B:  v = b;
            vteg_pkg::OPD_C:  v = c;
            vteg_pkg::OPD_D:  v = d;
            default:          v = a;
        endcase
        return v;
    endfunction

    // Captured item
    logic [1:0]         kind_reg, ttype_reg;
    logic [IDX_W-1:0]   i0_reg, i1_reg;
    logic signed [31:0] val_reg, a_reg, b_reg, c_reg, d_reg;

    // Working registers
    logic signed [31:0] q0_reg, q1_reg, x0_reg, x1_reg, r2_reg, r3_reg, r4_reg;
    logic signed [63:0] prod_reg, e_reg, g0_reg, g1_reg;
    logic signed [63:0] energy_reg, gread_reg;
    logic               sat_reg, bad_reg;
    logic [IDX_W-1:0]   clr_reg;

    // Result register
    logic [63:0] out_energy_reg, out_grad_reg;
    logic        out_ovf_reg, out_bad_reg;

    logic [31:0]        coord_rdata;
    logic [63:0]        grad_rdata;
    logic [IDX_W-1:0]   grad_addr;
    logic [64:0]        gsum;
    logic [64:0]        esum;
    logic [32:0]        dx0, dx1, sprod;
    logic signed [31:0] opa_val, opb_val;
    logic signed [63:0] scaled, halved;
    logic               sat_set;

    assign sts.kind     = kind_reg;
    assign sts.ttype    = ttype_reg;
    assign sts.clr_last = (clr_reg == IDX_W'(NUM_COORDS - 1));

    // Table address and write data
    always_comb
    begin
        unique case (cmd.grad_sel)
            vteg_pkg::GADR_I0:  grad_addr = i0_reg;
            vteg_pkg::GADR_I1:  grad_addr = i1_reg;
            default:            grad_addr = clr_reg;
        endcase
    end

    assign gsum = sat_add(grad_rdata, (cmd.grad_sel == vteg_pkg::GADR_I1) ? g1_reg : g0_reg);
    assign esum = sat_add(energy_reg, e_reg);

    vteg_ram #(.WIDTH(32), .DEPTH(NUM_COORDS)) u_coord_ram (
        .clk   (clk),
        .we    (cmd.coord_we),
        .waddr (i0_reg),
        .wdata (val_reg),
        .re    (cmd.coord_re),
        .raddr (cmd.coord_sel_i1 ? i1_reg : i0_reg),
        .rdata (coord_rdata)
    );

    vteg_ram #(.WIDTH(64), .DEPTH(NUM_COORDS)) u_grad_ram (
        .clk   (clk),
        .we    (cmd.grad_we),
        .waddr (grad_addr),
        .wdata (cmd.grad_zero ? 64'd0 : gsum[63:0]),
        .re    (cmd.grad_re),
        .raddr (grad_addr),
        .rdata (grad_rdata)
    );

    // Differences, operand select and product scaling
    assign dx0     = sat32({{32{q0_reg[31]}}, q0_reg} - {{32{b_reg[31]}}, b_reg});
    assign dx1     = sat32({{32{q1_reg[31]}}, q1_reg} - {{32{c_reg[31]}}, c_reg});
    assign opa_val = opd_pick(cmd.opa, q0_reg, r2_reg, r3_reg, r4_reg, x0_reg, x1_reg,
                              a_reg, b_reg, c_reg, d_reg);
    assign opb_val = opd_pick(cmd.opb, q0_reg, r2_reg, r3_reg, r4_reg, x0_reg, x1_reg,
                              a_reg, b_reg, c_reg, d_reg);
    assign scaled  = prod_reg >>> FRAC_BITS;
    assign halved  = prod_reg >>> (FRAC_BITS + 1);
    assign sprod   = sat32(scaled);

    // Saturation events of this cycle
    always_comb
    begin
        sat_set = 1'b0;
        if (cmd.sub && (ttype_reg != vteg_pkg::TERM_QUART) && dx0[32])
        begin
            sat_set = 1'b1;
        end
        if (cmd.sub && (ttype_reg == vteg_pkg::TERM_CROSS) && dx1[32])
        begin
            sat_set = 1'b1;
        end
        if (cmd.acc_en && sprod[32] && ((cmd.dst == vteg_pkg::DST_R2) ||
            (cmd.dst == vteg_pkg::DST_R3) || (cmd.dst == vteg_pkg::DST_R4)))
        begin
            sat_set = 1'b1;
        end
        if (cmd.grad_we && !cmd.grad_zero && gsum[64])
        begin
            sat_set = 1'b1;
        end
        if (cmd.e_commit && esum[64])
        begin
            sat_set = 1'b1;
        end
    end

    // Energy, sticky flag and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            sat_reg    <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_energy)
            begin
                energy_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.e_commit)
                begin
                    energy_reg <= esum[63:0];
                end
                if (sat_set)
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Item capture and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= in_user[1:0];
            ttype_reg <= in_user[3:2];
            i0_reg    <= idx_mod(in_data[7:0]);
            i1_reg    <= idx_mod(in_data[15:8]);
            val_reg   <= in_data[47:16];
            a_reg     <= in_data[79:48];
            b_reg     <= in_data[111:80];
            c_reg     <= in_data[143:112];
            d_reg     <= in_data[175:144];
            gread_reg <= '0;
            bad_reg   <= (in_user[1:0] == vteg_pkg::KIND_EVAL) &&
                         (in_user[3:2] == vteg_pkg::TERM_BAD);
        end
        if (cmd.cap_gread)
        begin
            gread_reg <= grad_rdata;
        end
        if (cmd.ld_q0)
        begin
            q0_reg <= coord_rdata;
        end
        if (cmd.ld_q1)
        begin
            q1_reg <= coord_rdata;
        end
        if (cmd.sub)
        begin
            x0_reg <= dx0[31:0];
            x1_reg <= dx1[31:0];
        end
        if (cmd.init)
        begin
            e_reg  <= '0;
            g0_reg <= (ttype_reg == vteg_pkg::TERM_QUART) ? {{32{a_reg[31]}}, a_reg} : 64'sd0;
            g1_reg <= '0;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= opa_val * opb_val;
        end
        if (cmd.acc_en)
        begin
            unique case (cmd.dst)
                vteg_pkg::DST_R2:   r2_reg <= sprod[31:0];
                vteg_pkg::DST_R3:   r3_reg <= sprod[31:0];
                vteg_pkg::DST_R4:   r4_reg <= sprod[31:0];
                vteg_pkg::DST_E:    e_reg  <= e_reg + scaled;
                vteg_pkg::DST_EH:   e_reg  <= e_reg + halved;
                vteg_pkg::DST_G0X1: g0_reg <= g0_reg + scaled;
                vteg_pkg::DST_G0X2: g0_reg <= g0_reg + (scaled <<< 1);
                vteg_pkg::DST_G0X3: g0_reg <= g0_reg + scaled + (scaled <<< 1);
                vteg_pkg::DST_G0X4: g0_reg <= g0_reg + (scaled <<< 2);
                vteg_pkg::DST_G1:   g1_reg <= g1_reg + scaled;
                default:            e_reg  <= e_reg;
            endcase
        end
        if (cmd.out_load)
        begin
            out_energy_reg <= energy_reg;
            out_grad_reg   <= gread_reg;
            out_ovf_reg    <= sat_reg;
            out_bad_reg    <= bad_reg;
        end
    end

    assign out_data = {out_grad_reg, out_energy_reg};
    assign out_user = {out_bad_reg, out_ovf_reg};

endmodule

[src/vteg_ctrl.sv]
// Controller: sequences table accesses and multiply steps for each item.
module vteg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  vteg_pkg::sts_t sts,
    output vteg_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DISP = 4'd2;
    localparam logic [3:0] ST_RDG  = 4'd3;
    localparam logic [3:0] ST_LQ0  = 4'd4;
    localparam logic [3:0] ST_LQ1  = 4'd5;
    localparam logic [3:0] ST_SUB  = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_ACC  = 4'd8;
    localparam logic [3:0] ST_GR0  = 4'd9;
    localparam logic [3:0] ST_GW0  = 4'd10;
    localparam logic [3:0] ST_GR1  = 4'd11;
    localparam logic [3:0] ST_GW1  = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    logic [3:0]          state_reg, state_next;
    vteg_pkg::step_idx_t step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    vteg_pkg::step_t     op;

    assign op        = vteg_pkg::step_op(sts.ttype, step_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                cmd.grad_we   = 1'b1;
                cmd.grad_zero = 1'b1;
                cmd.grad_sel  = vteg_pkg::GADR_CLR;
                cmd.clr_step  = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                unique case (sts.kind)
                    vteg_pkg::KIND_LOAD:
                    begin
                        cmd.coord_we  = 1'b1;
                        cmd.grad_we   = 1'b1;
                        cmd.grad_zero = 1'b1;
                        cmd.grad_sel  = vteg_pkg::GADR_I0;
                        state_next    = ST_DONE;
                    end
                    vteg_pkg::KIND_READ:
                    begin
                        cmd.grad_re  = 1'b1;
                        cmd.grad_sel = vteg_pkg::GADR_I0;
                        state_next   = ST_RDG;
                    end
                    vteg_pkg::KIND_CLEAR:
                    begin
                        cmd.clr_energy = 1'b1;
                        state_next     = ST_DONE;
                    end
                    default:
                    begin
                        if (sts.ttype == vteg_pkg::TERM_BAD)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.coord_re = 1'b1;
                            cmd.init     = 1'b1;
                            state_next   = ST_LQ0;
                        end
                    end
                endcase
            end
            ST_RDG:
            begin
                cmd.cap_gread = 1'b1;
                state_next    = ST_DONE;
            end
            ST_LQ0:
            begin
                cmd.ld_q0 = 1'b1;
                if (sts.ttype == vteg_pkg::TERM_CROSS)
                begin
                    cmd.coord_re     = 1'b1;
                    cmd.coord_sel_i1 = 1'b1;
                    state_next       = ST_LQ1;
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end
            ST_LQ1:
            begin
                cmd.ld_q1  = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.opa    = op.opa;
                cmd.opb    = op.opb;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.dst    = op.dst;
                if (op.last)
                begin
                    state_next = ST_GR0;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_GR0:
            begin
                cmd.grad_re  = 1'b1;
                cmd.grad_sel = vteg_pkg::GADR_I0;
                state_next   = ST_GW0;
            end
            ST_GW0:
            begin
                cmd.grad_we  = 1'b1;
                cmd.grad_sel = vteg_pkg::GADR_I0;
                cmd.e_commit = 1'b1;
                state_next   = (sts.ttype == vteg_pkg::TERM_CROSS) ? ST_GR1 : ST_DONE;
            end
            ST_GR1:
            begin
                cmd.grad_re  = 1'b1;
                cmd.grad_sel = vteg_pkg::GADR_I1;
                state_next   = ST_GW1;
            end
            ST_GW1:
            begin
                cmd.grad_we  = 1'b1;
                cmd.grad_sel = vteg_pkg::GADR_I1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat held until taken
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[tb/sv/valence_term_energy_gradient_tb.sv]
// Self-checking testbench for the valence term energy and gradient unit.
`timescale 1ns / 1ps

module valence_term_energy_gradient_tb;

    localparam int  FRAC = 24;
    localparam longint LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  ttype;
        logic [7:0]  i0;
        logic [7:0]  i1;
        logic [31:0] val;
        logic [31:0] ca;
        logic [31:0] cb;
        logic [31:0] cc;
        logic [31:0] cd;
    } op_t;

    typedef struct packed {
        logic [63:0] energy;
        logic [63:0] gread;
        logic        ovf;
        logic        bad;
    } res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    valence_term_energy_gradient DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state
    logic signed [31:0] coord_mirror [256];
    logic signed [63:0] grad_mirror [256];
    logic signed [63:0] energy_mirror;
    logic               sat_mirror;

    op_t    pending_ops[$];
    res_t   expected_res[$];
    int     errors = 0;
    longint cycle_cnt = 0;
    bit     stim_done = 0;
    bit     send_pause = 0;
    bit     in_fire = 0;
    int     hold_off = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Floor-scaled product of two Q8.24 values
    function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int s);
        logic signed [63:0] p;
        p = a * b;
        return p >>> s;
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            sat_mirror = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat_mirror = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat_mirror = 1;
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    // Work out the result beat for one accepted item
    function automatic res_t term_result(input op_t op);
        res_t r;
        logic signed [63:0] q0, q1, a, b, c, d, x0, x1, t, e, g0, g1, q2, q3, q4;
        a = signed'(op.ca); b = signed'(op.cb); c = signed'(op.cc); d = signed'(op.cd);
        r = '0;
        if (op.kind == vteg_pkg::KIND_LOAD)
        begin
            coord_mirror[op.i0] = op.val;
            grad_mirror[op.i0] = 0;
        end
        else if (op.kind == vteg_pkg::KIND_READ)
            r.gread = grad_mirror[op.i0];
        else if (op.kind == vteg_pkg::KIND_CLEAR)
        begin
            energy_mirror = 0;
            sat_mirror = 0;
        end
        else if (op.ttype == vteg_pkg::TERM_BAD)
            r.bad = 1;
        else
        begin
            q0 = coord_mirror[op.i0];
            if (op.ttype == vteg_pkg::TERM_HARM)
            begin
                x0 = sat32(q0 - b);
                t = sat32(mulq(x0, x0, FRAC));
                e = mulq(a, t, FRAC + 1);
                g0 = mulq(a, x0, FRAC);
                energy_mirror = sat_add(energy_mirror, e);
                grad_mirror[op.i0] = sat_add(grad_mirror[op.i0], g0);
            end
            else if (op.ttype == vteg_pkg::TERM_QUART)
            begin
                q2 = sat32(mulq(q0, q0, FRAC));
                q3 = sat32(mulq(q2, q0, FRAC));
                q4 = sat32(mulq(q3, q0, FRAC));
                e = mulq(a, q0, FRAC) + mulq(b, q2, FRAC) + mulq(c, q3, FRAC)
                  + mulq(d, q4, FRAC);
                g0 = a + 2 * mulq(b, q0, FRAC) + 3 * mulq(c, q2, FRAC) + 4 * mulq(d, q3, FRAC);
                energy_mirror = sat_add(energy_mirror, e);
                grad_mirror[op.i0] = sat_add(grad_mirror[op.i0], g0);
            end
            else
            begin
                q1 = coord_mirror[op.i1];
                x0 = sat32(q0 - b);
                x1 = sat32(q1 - c);
                t = sat32(mulq(x0, x1, FRAC));
                e = mulq(a, t, FRAC);
                g0 = mulq(a, x1, FRAC);
                g1 = mulq(a, x0, FRAC);
                energy_mirror = sat_add(energy_mirror, e);
                grad_mirror[op.i0] = sat_add(grad_mirror[op.i0], g0);
                grad_mirror[op.i1] = sat_add(grad_mirror[op.i1], g1);
            end
        end
        r.energy = energy_mirror;
        r.ovf = sat_mirror;
        return r;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h01000000 : 32'hff000000;
            3: return $urandom;
            default: return {{8{1'b0}}, 24'($urandom)} - 32'h00800000
                            + (32'($urandom_range(0, 7)) << 24) - 32'h04000000;
        endcase
    endfunction

    // Build one item with random coefficients
    function automatic op_t make_op(input logic [1:0] k, input logic [1:0] tt,
                                    input logic [7:0] a0, input logic [7:0] a1,
                                    input logic [31:0] v);
        op_t op;
        op.kind = k; op.ttype = tt; op.i0 = a0; op.i1 = a1; op.val = v;
        op.ca = rand_q(); op.cb = rand_q(); op.cc = rand_q(); op.cd = rand_q();
        return op;
    endfunction

    // Stimulus
    initial
    begin
        op_t op;
        int  r;
        // directed: loads at extremes, every term, same-index cross, bad type, reads, clear
        pending_ops.push_back(make_op(vteg_pkg::KIND_LOAD, 2'd0, 8'd0, 8'd0, 32'h7fffffff));
        pending_ops.push_back(make_op(vteg_pkg::KIND_LOAD, 2'd3, 8'd255, 8'hff, 32'h80000000));
        pending_ops.push_back(make_op(vteg_pkg::KIND_LOAD, 2'd1, 8'd1, 8'd0, 32'h01800000));
        pending_ops.push_back(make_op(vteg_pkg::KIND_LOAD, 2'd2, 8'd2, 8'd0, 32'hfe400000));
        for (int t = 0; t < 4; t++)
        begin
            pending_ops.push_back(make_op(vteg_pkg::KIND_EVAL, 2'(t), 8'd0, 8'd255, 0));
            pending_ops.push_back(make_op(vteg_pkg::KIND_EVAL, 2'(t), 8'd1, 8'd2, 0));
        end
        op = make_op(vteg_pkg::KIND_EVAL, vteg_pkg::TERM_CROSS, 8'd2, 8'd2, 0);
        pending_ops.push_back(op);
        op.ca = 32'h7fffffff; op.cb = 32'h80000000; op.cc = 32'h80000000; op.cd = 32'h7fffffff;
        for (int t = 0; t < 3; t++)
        begin
            op.ttype = 2'(t); op.i0 = 8'd255; op.i1 = 8'd0;
            pending_ops.push_back(op);
        end
        pending_ops.push_back(make_op(vteg_pkg::KIND_READ, 2'd3, 8'd0, 8'd0, 0));
        pending_ops.push_back(make_op(vteg_pkg::KIND_READ, 2'd0, 8'd2, 8'd0, 0));
        pending_ops.push_back(make_op(vteg_pkg::KIND_READ, 2'd1, 8'd255, 8'd0, 0));
        pending_ops.push_back(make_op(vteg_pkg::KIND_CLEAR, 2'd2, 8'd7, 8'd9, 32'hffffffff));
        pending_ops.push_back(make_op(vteg_pkg::KIND_READ, 2'd0, 8'd1, 8'd0, 0));
        for (int i = 0; i < 256; i++)
            if (i > 2 && i < 255)
                pending_ops.push_back(make_op(vteg_pkg::KIND_LOAD, 2'($urandom), 8'(i),
                                              8'($urandom), rand_q()));
        // wait until drained, then a pause with nothing in flight
        wait (pending_ops.size() == 0 && expected_res.size() == 0);
        send_pause = 1;
        repeat (40) @(posedge clk);
        send_pause = 0;
        // random: mostly evaluations on loaded coordinates, with loads, reads and clears
        for (int n = 0; n < 500; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                op = make_op(vteg_pkg::KIND_EVAL, ($urandom_range(0, 19) == 0)
                             ? vteg_pkg::TERM_BAD : 2'($urandom_range(0, 2)),
                             8'($urandom), 8'($urandom), $urandom);
            else if (r < 70)
                op = make_op(vteg_pkg::KIND_LOAD, 2'($urandom), 8'($urandom), 8'($urandom),
                             rand_q());
            else if (r < 92)
                op = make_op(vteg_pkg::KIND_READ, 2'($urandom), 8'($urandom), 8'($urandom),
                             $urandom);
            else
                op = make_op(vteg_pkg::KIND_CLEAR, 2'($urandom), 8'($urandom), 8'($urandom),
                             $urandom);
            pending_ops.push_back(op);
        end
        stim_done = 1;
    end

    // Driver: offers beats at the falling edge with random gaps
    int gap = 0;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else if (s_tvalid && !in_fire)
            ;
        else if (gap > 0)
        begin
            gap <= gap - 1;
            s_tvalid <= 0;
        end
        else if (pending_ops.size() > 0 && !send_pause)
        begin
            op_t op;
            op = pending_ops.pop_front();
            s_tvalid <= 1;
            s_tuser <= {op.ttype, op.kind};
            s_tdata <= {op.cd, op.cc, op.cb, op.ca, op.val, op.i1, op.i0};
            expected_res.push_back(term_result(op));
            case ($urandom_range(0, 9))
                0, 1, 2: gap <= $urandom_range(1, 3);
                3:       gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : 0;
                default: gap <= 0;
            endcase
        end
        else
            s_tvalid <= 0;
    end

    // Receiver readiness, with one long hold-off while beats keep coming
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 0;
            hold_off <= 0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end
        else if (cycle_cnt > 2000 && cycle_cnt < 2003)
        begin
            hold_off <= 300;
            m_tready <= 0;
        end
        else if (cycle_cnt > 6000 && cycle_cnt < 9000)
            m_tready <= 1;
        else
            m_tready <= ($urandom_range(0, 9) < 7) ||
                        ($urandom_range(0, 30) == 0 ? 0 : $urandom_range(0, 1));
    end

    // Monitor: note input accepts, compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        res_t exp_r;
        cycle_cnt <= cycle_cnt + 1;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_res.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat %h %h", $time, m_tdata, m_tuser);
            end
            else
            begin
                exp_r = expected_res.pop_front();
                if (m_tdata[63:0] !== exp_r.energy)
                begin
                    errors++;
                    $display("%0t: energy_sum exp %h got %h", $time, exp_r.energy,
                             m_tdata[63:0]);
                end
                if (m_tdata[127:64] !== exp_r.gread)
                begin
                    errors++;
                    $display("%0t: grad_read exp %h got %h", $time, exp_r.gread,
                             m_tdata[127:64]);
                end
                if (m_tuser[0] !== exp_r.ovf)
                begin
                    errors++;
                    $display("%0t: overflow_flag exp %b got %b", $time, exp_r.ovf, m_tuser[0]);
                end
                if (m_tuser[1] !== exp_r.bad)
                begin
                    errors++;
                    $display("%0t: bad_type exp %b got %b", $time, exp_r.bad, m_tuser[1]);
                end
            end
        end
    end

    // Reset, end of run and timeout
    initial
    begin
        rst_n = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        fork
            begin
                wait (stim_done && pending_ops.size() == 0 && !s_tvalid
                      && expected_res.size() == 0);
                repeat (50) @(posedge clk);
                if (errors == 0 && expected_res.size() == 0)
                    $display("valence_term_energy_gradient_tb: PASS");
                else
                    $display("valence_term_energy_gradient_tb: FAIL");
                $finish;
            end
            begin
                wait (cycle_cnt >= LIMIT_CYCLES);
                $display("%0t: timeout", $time);
                $display("valence_term_energy_gradient_tb: FAIL");
                $finish;
            end
        join
    end

endmodule
